### rtl/core/pss_pkg.sv
package pss_pkg;

   localparam int unsigned NODE_COUNT_DEF = 1024;
   localparam int unsigned NODE_FIELD_W   = 10;
   localparam int unsigned SET_W          = 8;
   localparam int unsigned COST_W         = 32;
   localparam int unsigned STEP_W         = 4;

   localparam logic [STEP_W-1:0] NO_PAIR_DIST = 4'd8;
   localparam logic [COST_W-1:0] SAT_MAX      = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_VISIT = 2'd2,
      OP_CLOSE = 2'd3
   } op_type;

   // Least distance between two set bits of a state set, NO_PAIR_DIST when
   // fewer than two bits are set.
   function automatic logic [STEP_W-1:0] min_bit_gap(input logic [SET_W-1:0] set);
      logic [STEP_W-1:0] best;
      logic [STEP_W-1:0] last;
      logic              seen;
      logic [STEP_W-1:0] gap;
      best = NO_PAIR_DIST;
      last = '0;
      seen = 1'b0;
      for (int i = 0; i < SET_W; i++) begin
         if (set[i]) begin
            gap = STEP_W'(i) - last;
            if (seen && (gap < best)) begin
               best = gap;
            end
            last = STEP_W'(i);
            seen = 1'b1;
         end
      end
      return best;
   endfunction

   // Reduces a node field modulo the store depth by restoring subtraction of
   // shifted copies of the constant depth. At most eight steps are live for
   // depths of four and up; depths of 1024 and up leave the index unchanged.
   function automatic logic [NODE_FIELD_W-1:0] wrap_index(
      input logic [NODE_FIELD_W-1:0] idx,
      input int unsigned             count
   );
      logic [NODE_FIELD_W:0] rem;
      logic [31:0]           shifted;
      rem = {1'b0, idx};
      for (int k = 7; k >= 0; k--) begin
         shifted = 32'(count) << k;
         if ((shifted < (32'd1 << NODE_FIELD_W)) && (32'(rem) >= shifted)) begin
            rem = rem - (NODE_FIELD_W + 1)'(shifted);
         end
      end
      return rem[NODE_FIELD_W-1:0];
   endfunction

endpackage

### rtl/core/parsimony_state_set_scorer_unit.sv
// Channel | Ports                                          | Direction
// --------+------------------------------------------------+----------
// request | req_valid, req_stall, req_op, req_node,        | in
//         | req_left_child, req_right_child, req_leaf_mask |
// result  | rsp_valid, rsp_stall, rsp_total_cost,          | out
//         | rsp_root_cost (close only)                     |
//
// One item is taken per cycle while the result side keeps moving.
// The node store is read at the transfer edge; the item completes in the
// execute stage from the registered read data, and a close result is loaded
// into the output register when it completes. A visit right behind the write of its
// child gets the new set through a forwarding register.
// Synchronous reset clears the running total and all valid flags; the node
// store holds no reset value. A stalled close holds the execute stage, which
// in turn stalls the request side.
module parsimony_state_set_scorer_unit #(
   parameter int unsigned NODE_COUNT = pss_pkg::NODE_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_op,
   input  logic [pss_pkg::NODE_FIELD_W-1:0]    req_node,
   input  logic [pss_pkg::NODE_FIELD_W-1:0]    req_left_child,
   input  logic [pss_pkg::NODE_FIELD_W-1:0]    req_right_child,
   input  logic [pss_pkg::SET_W-1:0]           req_leaf_mask,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pss_pkg::COST_W-1:0]          rsp_total_cost,
   output logic [pss_pkg::STEP_W-1:0]          rsp_root_cost
);
   import pss_pkg::*;

   localparam int unsigned IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

   logic [SET_W-1:0] mem [NODE_COUNT];

   // Request decode and read addresses.
   logic              accept;
   op_type            req_op_t;
   logic [IDX_W-1:0]  node_idx;
   logic [IDX_W-1:0]  left_idx;
   logic [IDX_W-1:0]  right_idx;
   logic [IDX_W-1:0]  rd_addr_a;
   logic [IDX_W-1:0]  rd_addr_b;

   // Execute stage.
   logic              s1_valid_ff;
   op_type            s1_op_ff;
   logic [IDX_W-1:0]  s1_node_ff;
   logic [SET_W-1:0]  s1_leaf_ff;
   logic [SET_W-1:0]  rd_a_ff;
   logic [SET_W-1:0]  rd_b_ff;
   logic              fwd_a_ff;
   logic              fwd_b_ff;
   logic [SET_W-1:0]  fwd_data_ff;
   logic              fwd_a_in;
   logic              fwd_b_in;
   logic              s1_fire;
   logic [SET_W-1:0]  set_a;
   logic [SET_W-1:0]  set_b;
   logic [SET_W-1:0]  set_and;
   logic [SET_W-1:0]  set_or;
   logic [STEP_W-1:0] gap;
   logic [STEP_W-1:0] step;
   logic [COST_W:0]   cost_sum;
   logic [COST_W-1:0] cost_total_ff;
   logic [COST_W-1:0] cost_total_in;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [SET_W-1:0]  wr_data;

   // Output register.
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [COST_W-1:0] rsp_total_cost_ff;
   logic [STEP_W-1:0] rsp_root_cost_ff;
   logic              rsp_free;

   assign req_op_t  = op_type'(req_op);
   assign node_idx  = IDX_W'(wrap_index(req_node, NODE_COUNT));
   assign left_idx  = IDX_W'(wrap_index(req_left_child, NODE_COUNT));
   assign right_idx = IDX_W'(wrap_index(req_right_child, NODE_COUNT));

   // A close compares the root with its child; a visit reads both children.
   assign rd_addr_a = (req_op_t == OP_CLOSE) ? node_idx : left_idx;
   assign rd_addr_b = (req_op_t == OP_CLOSE) ? left_idx : right_idx;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && ((s1_op_ff != OP_CLOSE) || rsp_free);
   assign req_stall = s1_valid_ff && !s1_fire;
   assign accept    = req_valid && !req_stall;

   // The store returns the old set when the item ahead writes the same entry
   // in the cycle of the read, so that write is forwarded.
   assign fwd_a_in = wr_en && (wr_addr == rd_addr_a);
   assign fwd_b_in = wr_en && (wr_addr == rd_addr_b);

   assign set_a   = fwd_a_ff ? fwd_data_ff : rd_a_ff;
   assign set_b   = fwd_b_ff ? fwd_data_ff : rd_b_ff;
   assign set_and = set_a & set_b;
   assign set_or  = set_a | set_b;
   assign gap     = min_bit_gap(set_or);

   always_comb begin
      step          = '0;
      wr_en         = 1'b0;
      wr_addr       = s1_node_ff;
      wr_data       = s1_leaf_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      case (s1_op_ff)
         OP_LOAD: begin
            wr_en = s1_fire;
         end
         OP_VISIT: begin
            wr_en   = s1_fire;
            wr_data = (set_and == '0) ? set_or : set_and;
            step    = (set_and == '0) ? gap : '0;
         end
         OP_CLOSE: begin
            step = (set_and == '0) ? gap : '0;
            if (s1_fire) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase

      cost_sum = {1'b0, cost_total_ff} + (COST_W + 1)'(step);
      cost_total_in = cost_total_ff;
      if (s1_fire) begin
         if (s1_op_ff == OP_CLEAR) begin
            cost_total_in = '0;
         end else if (cost_sum[COST_W]) begin
            cost_total_in = SAT_MAX;
         end else begin
            cost_total_in = cost_sum[COST_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (accept) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         cost_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff   <= accept || (s1_valid_ff && !s1_fire);
         cost_total_ff <= cost_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= req_op_t;
         s1_node_ff  <= node_idx;
         s1_leaf_ff  <= req_leaf_mask;
         fwd_a_ff    <= fwd_a_in;
         fwd_b_ff    <= fwd_b_in;
         fwd_data_ff <= wr_data;
      end
      if (s1_fire && (s1_op_ff == OP_CLOSE)) begin
         rsp_total_cost_ff <= cost_total_in;
         rsp_root_cost_ff  <= step;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_total_cost = rsp_total_cost_ff;
   assign rsp_root_cost  = rsp_root_cost_ff;

   a_rsp_from_close: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && rsp_stall))
         |-> $past(s1_fire && (s1_op_ff == OP_CLOSE)))
      else $error("result appeared without a completed close");

   a_write_needs_item: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> s1_valid_ff)
      else $error("node store written with an empty execute stage");

   a_cost_monotonic: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && (s1_op_ff != OP_CLEAR)) |=> (cost_total_ff >= $past(cost_total_ff)))
      else $error("running total decreased without a clear");

   a_root_cost_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_root_cost_ff <= NO_PAIR_DIST))
      else $error("root step out of range");

endmodule

### dv/parsimony_state_set_scorer_unit_test.sv
module parsimony_state_set_scorer_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import pss_pkg::*;

   localparam int unsigned STORE_DEPTH = 1024;
   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef struct {
      logic [COST_W-1:0] total;
      logic [STEP_W-1:0] root_step;
   } close_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   op_type                  req_op = OP_CLEAR;
   logic [NODE_FIELD_W-1:0] req_node = '0;
   logic [NODE_FIELD_W-1:0] req_left_child = '0;
   logic [NODE_FIELD_W-1:0] req_right_child = '0;
   logic [SET_W-1:0]        req_leaf_mask = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [COST_W-1:0]       rsp_total_cost;
   logic [STEP_W-1:0]       rsp_root_cost;

   // Shadow of the block: state sets per node and the running cost.
   logic [SET_W-1:0]        shadow_sets [STORE_DEPTH];
   bit                      shadow_written [STORE_DEPTH];
   logic [NODE_FIELD_W-1:0] written_nodes [$];
   logic [COST_W-1:0]       running_cost = '0;
   close_result_type        close_results_q [$];

   logic idle_enable = 1'b0;
   int   stall_left = 0;
   int   items_sent = 0;
   int   fail_count = 0;
   int   cycle_count = 0;

   parsimony_state_set_scorer_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_node        (req_node),
      .req_left_child  (req_left_child),
      .req_right_child (req_right_child),
      .req_leaf_mask   (req_leaf_mask),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_total_cost  (rsp_total_cost),
      .rsp_root_cost   (rsp_root_cost)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Result side back-pressure in random bursts while idle_enable is set.
   always @(posedge clock) begin
      if (!idle_enable) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 11) == 0) begin
         stall_left = $urandom_range(0, 17);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic [STEP_W-1:0] closest_pair_gap(input logic [SET_W-1:0] states);
      int               prev;
      logic [STEP_W-1:0] best;
      best = NO_PAIR_DIST;
      prev = -1;
      for (int i = 0; i < SET_W; i++) begin
         if (states[i]) begin
            if (prev >= 0 && (i - prev) < best) begin
               best = STEP_W'(i - prev);
            end
            prev = i;
         end
      end
      return best;
   endfunction

   function automatic void add_to_total(input logic [STEP_W-1:0] amount);
      logic [COST_W:0] sum;
      sum = {1'b0, running_cost} + (COST_W + 1)'(amount);
      running_cost = sum[COST_W] ? SAT_MAX : sum[COST_W-1:0];
   endfunction

   function automatic void store_set(input logic [NODE_FIELD_W-1:0] node,
                                     input logic [SET_W-1:0] states);
      shadow_sets[node] = states;
      if (!shadow_written[node]) begin
         shadow_written[node] = 1'b1;
         written_nodes.push_back(node);
      end
   endfunction

   // Applies one accepted transfer to the shadow state.
   function automatic void track_transfer(input op_type op,
                                          input logic [NODE_FIELD_W-1:0] node,
                                          input logic [NODE_FIELD_W-1:0] left_idx,
                                          input logic [NODE_FIELD_W-1:0] right_idx,
                                          input logic [SET_W-1:0] mask);
      logic [SET_W-1:0] a;
      logic [SET_W-1:0] b;
      logic [SET_W-1:0] merged;
      close_result_type due;
      case (op)
         OP_CLEAR: begin
            running_cost = '0;
         end
         OP_LOAD: begin
            store_set(node, mask);
         end
         OP_VISIT: begin
            a = shadow_sets[left_idx];
            b = shadow_sets[right_idx];
            merged = a & b;
            if (merged == '0) begin
               merged = a | b;
               add_to_total(closest_pair_gap(merged));
            end
            store_set(node, merged);
         end
         default: begin
            a = shadow_sets[node];
            b = shadow_sets[left_idx];
            due.root_step = ((a & b) == '0) ? closest_pair_gap(a | b) : '0;
            add_to_total(due.root_step);
            due.total = running_cost;
            close_results_q.push_back(due);
         end
      endcase
   endfunction

   function automatic logic [SET_W-1:0] rand_states();
      case ($urandom_range(0, 5))
         0: return '1;
         1: return SET_W'(1) << $urandom_range(0, SET_W - 1);
         2: return (SET_W'(1) << $urandom_range(0, SET_W - 1)) |
                   (SET_W'(1) << $urandom_range(0, SET_W - 1));
         3: return '0;
         default: return SET_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [NODE_FIELD_W-1:0] rand_node();
      return NODE_FIELD_W'($urandom_range(0, 1023));
   endfunction

   function automatic logic [SET_W-1:0] rand_mask();
      return SET_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [NODE_FIELD_W-1:0] pick_written();
      return written_nodes[$urandom_range(0, written_nodes.size() - 1)];
   endfunction

   task automatic send_op(input op_type op,
                          input logic [NODE_FIELD_W-1:0] node,
                          input logic [NODE_FIELD_W-1:0] left_idx,
                          input logic [NODE_FIELD_W-1:0] right_idx,
                          input logic [SET_W-1:0] mask);
      if (idle_enable && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_node <= node;
      req_left_child <= left_idx;
      req_right_child <= right_idx;
      req_leaf_mask <= mask;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_transfer(op, node, left_idx, right_idx, mask);
      items_sent++;
   endtask

   always @(posedge clock) begin : check_close
      close_result_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (close_results_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual total_cost %0d root_cost %0d",
                     $time, rsp_total_cost, rsp_root_cost);
            fail_count++;
         end else begin
            due = close_results_q.pop_front();
            if (rsp_total_cost !== due.total) begin
               $display("%0t: total_cost mismatch, expected %0d, actual %0d",
                        $time, due.total, rsp_total_cost);
               fail_count++;
            end
            if (rsp_root_cost !== due.root_step) begin
               $display("%0t: root_cost mismatch, expected %0d, actual %0d",
                        $time, due.root_step, rsp_root_cost);
               fail_count++;
            end
         end
      end
   end

   // Root steps: empty sets, widest gap, overlapping sets.
   task automatic test_close_steps();
      send_op(OP_CLEAR, 10'h3FF, 10'h3FF, 10'h3FF, 8'hFF);
      send_op(OP_LOAD, 10'h000, 10'h000, 10'h000, 8'h00);
      send_op(OP_LOAD, 10'h3FF, 10'h155, 10'h2AA, 8'hFF);
      send_op(OP_LOAD, 10'h001, 10'h000, 10'h000, 8'h01);
      send_op(OP_LOAD, 10'h002, 10'h000, 10'h000, 8'h80);
      send_op(OP_CLOSE, 10'h000, 10'h000, 10'h3FF, 8'h00);
      send_op(OP_CLOSE, 10'h001, 10'h002, 10'h000, 8'hFF);
      send_op(OP_CLOSE, 10'h3FF, 10'h001, 10'h155, 8'h00);
   endtask

   // Visits: union cost, intersection, forwarding of a fresh write, a node that is
   // also its own child, and alternating bit patterns in the indices.
   task automatic test_visit_steps();
      send_op(OP_VISIT, 10'h003, 10'h001, 10'h002, 8'h00);
      send_op(OP_VISIT, 10'h004, 10'h003, 10'h3FF, 8'hFF);
      send_op(OP_LOAD, 10'h005, 10'h000, 10'h000, 8'h02);
      send_op(OP_VISIT, 10'h005, 10'h005, 10'h004, 8'h00);
      send_op(OP_VISIT, 10'h000, 10'h000, 10'h000, 8'h00);
      send_op(OP_VISIT, 10'h3FF, 10'h005, 10'h005, 8'h00);
      send_op(OP_CLOSE, 10'h3FF, 10'h005, 10'h000, 8'h00);
      send_op(OP_LOAD, 10'h155, 10'h000, 10'h000, 8'h55);
      send_op(OP_LOAD, 10'h2AA, 10'h000, 10'h000, 8'hAA);
      send_op(OP_VISIT, 10'h2AA, 10'h155, 10'h2AA, 8'h00);
      send_op(OP_CLOSE, 10'h155, 10'h000, 10'h000, 8'h00);
   endtask

   task automatic test_clear_total();
      send_op(OP_CLEAR, 10'h000, 10'h000, 10'h000, 8'h00);
      send_op(OP_CLOSE, 10'h002, 10'h002, 10'h000, 8'h00);
      send_op(OP_CLOSE, 10'h000, 10'h000, 10'h000, 8'h00);
   endtask

   // Sometimes clears the total, then loads some leaves, merges them bottom-up and closes on the last two nodes.
   task automatic grow_tree();
      logic [NODE_FIELD_W-1:0] live [$];
      logic [NODE_FIELD_W-1:0] a_idx;
      logic [NODE_FIELD_W-1:0] b_idx;
      logic [NODE_FIELD_W-1:0] dest;
      int                      pos;
      if ($urandom_range(0, 3) == 0) begin
         send_op(OP_CLEAR, rand_node(), rand_node(), rand_node(), rand_mask());
      end
      repeat ($urandom_range(2, 8)) begin
         dest = rand_node();
         send_op(OP_LOAD, dest, rand_node(), rand_node(), rand_states());
         live.push_back(dest);
      end
      while (live.size() > 2) begin
         pos = $urandom_range(0, live.size() - 1);
         a_idx = live[pos];
         live.delete(pos);
         pos = $urandom_range(0, live.size() - 1);
         b_idx = live[pos];
         live.delete(pos);
         case ($urandom_range(0, 3))
            0: dest = a_idx;
            1: dest = b_idx;
            default: dest = rand_node();
         endcase
         send_op(OP_VISIT, dest, a_idx, b_idx, rand_mask());
         live.push_back(dest);
      end
      send_op(OP_CLOSE, live[0], live[1], rand_node(), rand_mask());
   endtask

   task automatic test_random_trees(input int count);
      int stop_at;
      stop_at = items_sent + count;
      while (items_sent < stop_at) grow_tree();
   endtask

   // Operations in any order; reads only touch nodes that hold a set.
   task automatic test_random_noise(input int count);
      op_type op;
      repeat (count) begin
         op = op_type'($urandom_range(0, 3));
         case (op)
            OP_VISIT: send_op(op, rand_node(), pick_written(), pick_written(), rand_mask());
            OP_CLOSE: send_op(op, pick_written(), pick_written(), rand_node(), rand_mask());
            default:  send_op(op, rand_node(), rand_node(), rand_node(), rand_states());
         endcase
      end
   endtask

   task automatic test_back_to_back();
      idle_enable <= 1'b0;
      test_random_trees(150);
      test_random_noise(100);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      idle_enable <= 1'b1;
      test_close_steps();
      test_visit_steps();
      test_clear_total();
      test_random_trees(800);
      test_random_noise(250);
      test_back_to_back();
      req_valid <= 1'b0;
      while (close_results_q.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
